>>> design/brs_pkg.sv
// shared types, codes and constants of the byte randomness statistics unit
package brs_pkg;

    localparam int POINT_BYTES_DEF = 6;
    localparam int COUNT_BITS_DEF  = 32;

    localparam int HIST_BINS  = 256;
    localparam int BIN_BITS   = 8;
    localparam int HIST_BITS  = 32;
    localparam int TOTAL_BITS = 32;
    localparam int VSUM_BITS  = 40;
    localparam int BSQ_BITS   = 64;
    localparam int TRY_BITS   = 30;
    localparam int CORR_BITS  = 48;

    localparam logic [TRY_BITS-1:0] TRY_MAX = '1;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_REPORT = 2'd2
    } brs_req_t;

    typedef struct packed {
        logic [TRY_BITS-1:0] tries;
        logic [TRY_BITS-1:0] hits;
        logic                pend;
        logic                hit;
    } brs_mc_t;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] byte_total;
        logic [VSUM_BITS-1:0]  value_sum;
        logic [BSQ_BITS-1:0]   bin_square_sum;
        logic [TRY_BITS-1:0]   circle_tries;
        logic [TRY_BITS-1:0]   circle_hits;
        logic [CORR_BITS-1:0]  pair_product_sum;
        logic [CORR_BITS-1:0]  square_sum;
        logic                  count_saturated;
    } brs_rpt_t;

endpackage

>>> design/brs_hist.sv
// histogram memory with read-modify-write stage and running sum of squared bin counts
module brs_hist
    import brs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                add,
    input  logic                clear,
    input  logic [BIN_BITS-1:0] bin,
    output logic [BSQ_BITS-1:0] sq_now
);

    logic [HIST_BITS-1:0] hist_mem_reg [HIST_BINS];
    logic [HIST_BINS-1:0] bin_vld_reg;

    logic [HIST_BITS-1:0] rd_data_reg;
    logic                 rd_vld_reg;
    logic                 s1_vld_reg;
    logic [BIN_BITS-1:0]  s1_bin_reg;

    logic                 fw_vld_reg;
    logic [BIN_BITS-1:0]  fw_bin_reg;
    logic [HIST_BITS-1:0] fw_cnt_reg;

    logic [BSQ_BITS-1:0]  sq_reg;
    logic [BSQ_BITS-1:0]  sq_next;

    logic [HIST_BITS-1:0] cnt_old;
    logic [HIST_BITS-1:0] cnt_new;

    always_comb
    begin
        if (fw_vld_reg && (fw_bin_reg == s1_bin_reg))
        begin
            cnt_old = fw_cnt_reg;
        end
        else if (rd_vld_reg)
        begin
            cnt_old = rd_data_reg;
        end
        else
        begin
            cnt_old = '0;
        end
        cnt_new = cnt_old + HIST_BITS'(1);
        sq_now  = s1_vld_reg ? (sq_reg + BSQ_BITS'({cnt_old, 1'b1})) : sq_reg;
        sq_next = clear ? '0 : sq_now;
    end

    // memory port: one read, one write per cycle
    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            hist_mem_reg[s1_bin_reg] <= cnt_new;
        end
        if (add)
        begin
            rd_data_reg <= hist_mem_reg[bin];
        end
    end

    always_ff @(posedge clk)
    begin
        if (add)
        begin
            rd_vld_reg <= bin_vld_reg[bin];
            s1_bin_reg <= bin;
        end
        fw_bin_reg <= s1_bin_reg;
        fw_cnt_reg <= cnt_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_vld_reg <= '0;
            s1_vld_reg  <= 1'b0;
            fw_vld_reg  <= 1'b0;
            sq_reg      <= '0;
        end
        else
        begin
            s1_vld_reg <= add;
            fw_vld_reg <= s1_vld_reg && !clear;
            sq_reg     <= sq_next;
            if (clear)
            begin
                bin_vld_reg <= '0;
            end
            else if (s1_vld_reg)
            begin
                bin_vld_reg[s1_bin_reg] <= 1'b1;
            end
        end
    end

endmodule

>>> design/brs_point.sv
// monte carlo point gathering, squaring pipeline and circle counters
module brs_point
    import brs_pkg::*;
#(
    parameter int POINT_BYTES = POINT_BYTES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                add,
    input  logic                clear,
    input  logic [BIN_BITS-1:0] sample,
    output brs_mc_t             mc
);

    localparam int HALF = POINT_BYTES / 2;
    localparam int XW   = 8 * HALF;
    localparam int LAST = POINT_BYTES - 1;
    localparam int PW   = $clog2(POINT_BYTES);
    localparam logic [XW-1:0]   RMAX = '1;
    localparam logic [2*XW-1:0] R2   = (2*XW)'(RMAX) * (2*XW)'(RMAX);

    logic [7:0]    held_reg [LAST];
    logic [PW-1:0] pos_reg;
    logic [7:0]    pt [POINT_BYTES];
    logic [XW-1:0] x;
    logic [XW-1:0] y;
    logic          done;

    logic            p1_vld_reg;
    logic [XW-1:0]   x_reg;
    logic [XW-1:0]   y_reg;
    logic            p2_vld_reg;
    logic [2*XW-1:0] xx_reg;
    logic [2*XW-1:0] yy_reg;
    logic [2*XW:0]   rad_sum;
    logic            hit;

    logic [TRY_BITS-1:0] tries_reg;
    logic [TRY_BITS-1:0] hits_reg;
    logic [TRY_BITS-1:0] hits_now;

    for (genvar k = 0; k < POINT_BYTES; k++)
    begin : g_pt
        if (k == LAST)
        begin : g_live
            assign pt[k] = sample;
        end
        else
        begin : g_held
            assign pt[k] = held_reg[k];
        end
    end

    for (genvar k = 0; k < HALF; k++)
    begin : g_xy
        assign x[8*(HALF-1-k) +: 8] = pt[k];
        assign y[8*(HALF-1-k) +: 8] = pt[HALF+k];
    end

    assign done    = add && (pos_reg == PW'(LAST));
    assign rad_sum = {1'b0, xx_reg} + {1'b0, yy_reg};
    assign hit     = p2_vld_reg && (rad_sum <= {1'b0, R2});

    assign hits_now = (hit && (hits_reg != TRY_MAX)) ? hits_reg + TRY_BITS'(1) : hits_reg;

    assign mc.tries = tries_reg;
    assign mc.hits  = hits_now;
    assign mc.pend  = p1_vld_reg;
    assign mc.hit   = hit;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < LAST; k++)
        begin
            if (add && (pos_reg == PW'(k)))
            begin
                held_reg[k] <= sample;
            end
        end
        if (done)
        begin
            x_reg <= x;
            y_reg <= y;
        end
        xx_reg <= (2*XW)'(x_reg) * (2*XW)'(x_reg);
        yy_reg <= (2*XW)'(y_reg) * (2*XW)'(y_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            tries_reg  <= '0;
            hits_reg   <= '0;
        end
        else if (clear)
        begin
            pos_reg    <= '0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            tries_reg  <= '0;
            hits_reg   <= '0;
        end
        else
        begin
            p1_vld_reg <= done;
            p2_vld_reg <= p1_vld_reg;
            hits_reg   <= hits_now;
            if (add)
            begin
                pos_reg <= done ? '0 : pos_reg + PW'(1);
            end
            if (done && (tries_reg != TRY_MAX))
            begin
                tries_reg <= tries_reg + TRY_BITS'(1);
            end
        end
    end

endmodule

>>> design/brs_outq.sv
// report finishing stage and two-word output buffer
module brs_outq
    import brs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  brs_rpt_t rec,
    input  logic     pend,
    input  logic     late_hit,
    output logic     busy,
    output logic     out_valid,
    input  logic     out_stall,
    output brs_rpt_t head
);

    logic     r1_vld_reg;
    logic     r1_pend_reg;
    brs_rpt_t r1_rec_reg;
    brs_rpt_t fix;

    logic     main_vld_reg;
    logic     skid_vld_reg;
    brs_rpt_t main_reg;
    brs_rpt_t skid_reg;
    logic     take;
    logic     load;

    // add the hit of a point still in flight when the report was taken
    always_comb
    begin
        fix = r1_rec_reg;
        if (r1_pend_reg && late_hit && (r1_rec_reg.circle_hits != TRY_MAX))
        begin
            fix.circle_hits = r1_rec_reg.circle_hits + TRY_BITS'(1);
        end
    end

    assign take      = main_vld_reg && !out_stall;
    assign load      = !main_vld_reg || take;
    assign busy      = out_stall && (skid_vld_reg || (r1_vld_reg && main_vld_reg));
    assign out_valid = main_vld_reg;
    assign head      = main_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            r1_rec_reg  <= rec;
            r1_pend_reg <= pend;
        end
        if (load)
        begin
            main_reg <= skid_vld_reg ? skid_reg : fix;
            if (skid_vld_reg)
            begin
                skid_reg <= fix;
            end
        end
        else if (r1_vld_reg)
        begin
            skid_reg <= fix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_vld_reg   <= 1'b0;
            main_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            r1_vld_reg <= push;
            if (load)
            begin
                if (skid_vld_reg)
                begin
                    main_vld_reg <= 1'b1;
                    skid_vld_reg <= r1_vld_reg;
                end
                else
                begin
                    main_vld_reg <= r1_vld_reg;
                end
            end
            else if (r1_vld_reg)
            begin
                skid_vld_reg <= 1'b1;
            end
        end
    end

endmodule

>>> design/byte_randomness_statistics_unit.sv
// top level of the byte randomness statistics unit
// Takes one word per clock while in_stall is low: add a byte, clear all statistics, or
// report them. The 256-bin histogram sits in a synchronous RAM updated by
// read-modify-write with one word of forwarding, so bytes may arrive on every cycle, also
// into the same bin. A clear resets the bin valid bits at once. A report result passes the
// finishing stage and then waits in a two-word output buffer; in_stall rises only while
// out_stall is high and that buffer and the finishing stage together hold at least two
// reports.
module byte_randomness_statistics_unit
    import brs_pkg::*;
#(
    parameter int POINT_BYTES = POINT_BYTES_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            req_type,
    input  logic [BIN_BITS-1:0]   sample_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [TOTAL_BITS-1:0] byte_total,
    output logic [VSUM_BITS-1:0]  value_sum,
    output logic [BSQ_BITS-1:0]   bin_square_sum,
    output logic [TRY_BITS-1:0]   circle_tries,
    output logic [TRY_BITS-1:0]   circle_hits,
    output logic [CORR_BITS-1:0]  pair_product_sum,
    output logic [CORR_BITS-1:0]  square_sum,
    output logic                  count_saturated
);

    logic accept;
    logic add_req;
    logic clear_req;
    logic report_req;
    logic full;
    logic add_ok;

    logic [COUNT_BITS-1:0] cnt_reg;
    logic [VSUM_BITS-1:0]  vsum_reg;
    logic [CORR_BITS-1:0]  prod_reg;
    logic [CORR_BITS-1:0]  sqs_reg;
    logic [BIN_BITS-1:0]   first_reg;
    logic [BIN_BITS-1:0]   prev_reg;
    logic                  seen_reg;
    logic                  sat_reg;

    logic [BSQ_BITS-1:0] sq_now;
    brs_mc_t             mc;
    brs_rpt_t            rec;
    brs_rpt_t            head;
    logic [15:0]         pair_prod;
    logic [15:0]         self_prod;
    logic [15:0]         wrap_prod;

    assign accept = in_valid && !in_stall;

    always_comb
    begin
        add_req    = 1'b0;
        clear_req  = 1'b0;
        report_req = 1'b0;
        case (req_type)
            REQ_ADD:    add_req    = accept;
            REQ_CLEAR:  clear_req  = accept;
            REQ_REPORT: report_req = accept;
            default:    ;
        endcase
    end

    assign full      = (cnt_reg == '1);
    assign add_ok    = add_req && !full;
    assign pair_prod = 16'(prev_reg) * 16'(sample_byte);
    assign self_prod = 16'(sample_byte) * 16'(sample_byte);
    assign wrap_prod = 16'(prev_reg) * 16'(first_reg);

    always_comb
    begin
        rec.byte_total       = TOTAL_BITS'(cnt_reg);
        rec.value_sum        = vsum_reg;
        rec.bin_square_sum   = sq_now;
        rec.circle_tries     = mc.tries;
        rec.circle_hits      = mc.hits;
        rec.pair_product_sum = prod_reg + CORR_BITS'(wrap_prod);
        rec.square_sum       = sqs_reg;
        rec.count_saturated  = sat_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            vsum_reg  <= '0;
            prod_reg  <= '0;
            sqs_reg   <= '0;
            first_reg <= '0;
            prev_reg  <= '0;
            seen_reg  <= 1'b0;
            sat_reg   <= 1'b0;
        end
        else if (clear_req)
        begin
            cnt_reg   <= '0;
            vsum_reg  <= '0;
            prod_reg  <= '0;
            sqs_reg   <= '0;
            first_reg <= '0;
            prev_reg  <= '0;
            seen_reg  <= 1'b0;
            sat_reg   <= 1'b0;
        end
        else if (add_req && full)
        begin
            sat_reg <= 1'b1;
        end
        else if (add_ok)
        begin
            cnt_reg  <= cnt_reg + COUNT_BITS'(1);
            vsum_reg <= vsum_reg + VSUM_BITS'(sample_byte);
            sqs_reg  <= sqs_reg + CORR_BITS'(self_prod);
            prev_reg <= sample_byte;
            seen_reg <= 1'b1;
            if (seen_reg)
            begin
                prod_reg <= prod_reg + CORR_BITS'(pair_prod);
            end
            else
            begin
                first_reg <= sample_byte;
            end
        end
    end

    brs_hist u_hist (
        .clk    (clk),
        .rst_n  (rst_n),
        .add    (add_ok),
        .clear  (clear_req),
        .bin    (sample_byte),
        .sq_now (sq_now)
    );

    brs_point #(
        .POINT_BYTES (POINT_BYTES)
    ) u_point (
        .clk    (clk),
        .rst_n  (rst_n),
        .add    (add_ok),
        .clear  (clear_req),
        .sample (sample_byte),
        .mc     (mc)
    );

    brs_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (report_req),
        .rec       (rec),
        .pend      (mc.pend),
        .late_hit  (mc.hit),
        .busy      (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign byte_total       = head.byte_total;
    assign value_sum        = head.value_sum;
    assign bin_square_sum   = head.bin_square_sum;
    assign circle_tries     = head.circle_tries;
    assign circle_hits      = head.circle_hits;
    assign pair_product_sum = head.pair_product_sum;
    assign square_sum       = head.square_sum;
    assign count_saturated  = head.count_saturated;

endmodule

>>> tb/byte_randomness_statistics_unit_tb.sv
// self-checking testbench of the byte randomness statistics unit with a built-in statistics predictor
module byte_randomness_statistics_unit_tb
    import brs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TB_POINT_BYTES = 6;
    localparam int TB_COUNT_BITS  = 16;
    localparam int PT_HALF        = TB_POINT_BYTES / 2;
    localparam logic [63:0] COUNT_FULL = (64'd1 << TB_COUNT_BITS) - 64'd1;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_LEN    = 400;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] sample;
    } stat_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            req_type = REQ_ADD;
    logic [BIN_BITS-1:0]   sample_byte = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [TOTAL_BITS-1:0] byte_total;
    logic [VSUM_BITS-1:0]  value_sum;
    logic [BSQ_BITS-1:0]   bin_square_sum;
    logic [TRY_BITS-1:0]   circle_tries;
    logic [TRY_BITS-1:0]   circle_hits;
    logic [CORR_BITS-1:0]  pair_product_sum;
    logic [CORR_BITS-1:0]  square_sum;
    logic                  count_saturated;

    byte_randomness_statistics_unit #(
        .POINT_BYTES(TB_POINT_BYTES),
        .COUNT_BITS (TB_COUNT_BITS)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .sample_byte     (sample_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .byte_total      (byte_total),
        .value_sum       (value_sum),
        .bin_square_sum  (bin_square_sum),
        .circle_tries    (circle_tries),
        .circle_hits     (circle_hits),
        .pair_product_sum(pair_product_sum),
        .square_sum      (square_sum),
        .count_saturated (count_saturated)
    );

    always #10 clk = ~clk;

    stat_word_t pending_words[$];
    brs_rpt_t   expected_reports[$];
    stat_word_t next_word;

    int  in_idle_pct  = 0;
    int  out_idle_pct = 0;
    int  hold_requests = 0;
    int  hold_served   = 0;
    int  hold_left     = 0;
    logic in_taken = 1'b0;
    int  mismatches = 0;
    int  words_taken = 0;
    int  reports_checked = 0;
    int  cycle_count = 0;
    bit  saw_saturation = 1'b0;
    logic [7:0] last_pick = 8'h00;

    // predictor state
    logic [HIST_BITS-1:0] bin_count [HIST_BINS];
    logic [63:0]          count_acc;
    logic [VSUM_BITS-1:0] vsum_acc;
    logic [BSQ_BITS-1:0]  bsq_acc;
    logic [7:0]           point_buf [TB_POINT_BYTES];
    int                   point_idx;
    logic [TRY_BITS-1:0]  tries_acc;
    logic [TRY_BITS-1:0]  hits_acc;
    bit                   have_first;
    logic [7:0]           first_byte;
    logic [7:0]           prev_byte;
    logic [CORR_BITS-1:0] products_acc;
    logic [CORR_BITS-1:0] squares_acc;
    bit                   sat_seen;

    task automatic clear_stats();
        for (int i = 0; i < HIST_BINS; i++)
            bin_count[i] = '0;
        for (int i = 0; i < TB_POINT_BYTES; i++)
            point_buf[i] = '0;
        count_acc    = '0;
        vsum_acc     = '0;
        bsq_acc      = '0;
        point_idx    = 0;
        tries_acc    = '0;
        hits_acc     = '0;
        have_first   = 1'b0;
        first_byte   = '0;
        prev_byte    = '0;
        products_acc = '0;
        squares_acc  = '0;
        sat_seen     = 1'b0;
    endtask

    function automatic bit point_in_circle();
        logic [63:0]  x;
        logic [63:0]  y;
        logic [64:0]  rad;
        logic [129:0] lhs;
        logic [129:0] rad_sq;
        x = '0;
        y = '0;
        for (int k = 0; k < PT_HALF; k++)
        begin
            x = {x[55:0], point_buf[k]};
            y = {y[55:0], point_buf[PT_HALF + k]};
        end
        rad = (65'd1 << (8 * PT_HALF)) - 65'd1;
        lhs = {66'd0, x} * {66'd0, x} + {66'd0, y} * {66'd0, y};
        rad_sq = {65'd0, rad} * {65'd0, rad};
        return lhs <= rad_sq;
    endfunction

    task automatic add_sample(logic [7:0] b);
        logic [HIST_BITS-1:0] c;
        if (count_acc >= COUNT_FULL)
        begin
            sat_seen = 1'b1;
            return;
        end
        c = bin_count[b];
        bsq_acc = bsq_acc + {31'd0, c, 1'b1};
        bin_count[b] = c + HIST_BITS'(1);
        count_acc = count_acc + 64'd1;
        vsum_acc = vsum_acc + VSUM_BITS'(b);
        if (point_idx >= TB_POINT_BYTES)
            point_idx = 0;
        point_buf[point_idx] = b;
        point_idx++;
        if (point_idx >= TB_POINT_BYTES)
        begin
            point_idx = 0;
            if (tries_acc != TRY_MAX)
                tries_acc = tries_acc + TRY_BITS'(1);
            if (point_in_circle() && hits_acc != TRY_MAX)
                hits_acc = hits_acc + TRY_BITS'(1);
        end
        if (!have_first)
        begin
            have_first = 1'b1;
            first_byte = b;
        end
        else
            products_acc = products_acc + CORR_BITS'(prev_byte) * CORR_BITS'(b);
        squares_acc = squares_acc + CORR_BITS'(b) * CORR_BITS'(b);
        prev_byte = b;
    endtask

    task automatic absorb_word(logic [1:0] req, logic [7:0] b);
        brs_rpt_t r;
        case (req)
            REQ_ADD:
                add_sample(b);
            REQ_CLEAR:
                clear_stats();
            REQ_REPORT:
            begin
                r.byte_total       = count_acc[TOTAL_BITS-1:0];
                r.value_sum        = vsum_acc;
                r.bin_square_sum   = bsq_acc;
                r.circle_tries     = tries_acc;
                r.circle_hits      = hits_acc;
                r.pair_product_sum = products_acc
                                   + CORR_BITS'(prev_byte) * CORR_BITS'(first_byte);
                r.square_sum       = squares_acc;
                r.count_saturated  = sat_seen;
                if (sat_seen)
                    saw_saturation = 1'b1;
                expected_reports.push_back(r);
            end
            default:
                ;
        endcase
    endtask

    task automatic note_failure(string msg);
        if (mismatches < 50)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            note_failure($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic check_report();
        brs_rpt_t e;
        if (expected_reports.size() == 0)
        begin
            note_failure("report word with none pending");
            return;
        end
        e = expected_reports.pop_front();
        reports_checked++;
        check_field("byte_total", 64'(byte_total), 64'(e.byte_total));
        check_field("value_sum", 64'(value_sum), 64'(e.value_sum));
        check_field("bin_square_sum", bin_square_sum, e.bin_square_sum);
        check_field("circle_tries", 64'(circle_tries), 64'(e.circle_tries));
        check_field("circle_hits", 64'(circle_hits), 64'(e.circle_hits));
        check_field("pair_product_sum", 64'(pair_product_sum), 64'(e.pair_product_sum));
        check_field("square_sum", 64'(square_sum), 64'(e.square_sum));
        check_field("count_saturated", 64'(count_saturated), 64'(e.count_saturated));
    endtask

    // monitor
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                words_taken++;
                absorb_word(req_type, sample_byte);
            end
            if (out_valid && !out_stall)
                check_report();
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_words.size() != 0 && $urandom_range(99, 0) >= in_idle_pct)
            begin
                next_word = pending_words.pop_front();
                in_valid    <= 1'b1;
                req_type    <= next_word.req;
                sample_byte <= next_word.sample;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99, 0) < out_idle_pct);
    end

    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, expected_reports.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic put_word(logic [1:0] req, logic [7:0] b);
        stat_word_t w;
        w.req = req;
        w.sample = b;
        pending_words.push_back(w);
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(9, 0))
            0, 1, 2, 3: b = 8'($urandom);
            4, 5:       b = {6'd0, 2'($urandom)} + 8'h7E;
            6:          b = 8'h00;
            7:          b = 8'hFF;
            default:    b = last_pick;
        endcase
        last_pick = b;
        return b;
    endfunction

    task automatic random_burst(int n, int report_pct);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99, 0);
            if (r < 2)
                put_word(REQ_CLEAR, 8'($urandom));
            else if (r < 4)
                put_word(REQ_UNUSED, 8'($urandom));
            else if (r < 4 + report_pct)
                put_word(REQ_REPORT, 8'($urandom));
            else
                put_word(REQ_ADD, pick_byte());
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        clear_stats();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed
        in_idle_pct = 28;
        out_idle_pct = 28;
        put_word(REQ_REPORT, 8'h00);
        put_word(REQ_ADD, 8'h00);
        put_word(REQ_REPORT, 8'hFF);
        put_word(REQ_CLEAR, 8'hFF);
        put_word(REQ_ADD, 8'hC8);
        put_word(REQ_REPORT, 8'h00);
        put_word(REQ_ADD, 8'hFF);
        put_word(REQ_ADD, 8'hFF);
        put_word(REQ_ADD, 8'hFF);
        put_word(REQ_UNUSED, 8'hAA);
        put_word(REQ_REPORT, 8'h55);
        put_word(REQ_CLEAR, 8'h00);
        put_word(REQ_ADD, 8'hFF);
        put_word(REQ_ADD, 8'hFF);
        put_word(REQ_ADD, 8'hFF);
        put_word(REQ_ADD, 8'h00);
        put_word(REQ_ADD, 8'h00);
        put_word(REQ_ADD, 8'h00);
        put_word(REQ_REPORT, 8'h00);
        put_word(REQ_ADD, 8'hFF);
        put_word(REQ_ADD, 8'hFF);
        put_word(REQ_ADD, 8'hFF);
        put_word(REQ_ADD, 8'h00);
        put_word(REQ_ADD, 8'h00);
        put_word(REQ_ADD, 8'h01);
        put_word(REQ_REPORT, 8'h00);
        wait_drained();

        // long receiver hold-off while reports keep coming
        in_idle_pct = 0;
        hold_requests++;
        for (int i = 0; i < 16; i++)
        begin
            put_word(REQ_ADD, pick_byte());
            put_word(REQ_REPORT, 8'($urandom));
        end
        wait_drained();

        in_idle_pct = 28;
        out_idle_pct = 28;
        random_burst(700, 8);
        wait_drained();

        in_idle_pct = 0;
        out_idle_pct = 0;
        random_burst(600, 8);
        wait_drained();

        in_idle_pct = 28;
        out_idle_pct = 28;
        random_burst(700, 30);
        put_word(REQ_CLEAR, 8'h00);
        put_word(REQ_REPORT, 8'h00);
        wait_drained();

        repeat (8) @(posedge clk);
        $display("covered %0d words and %0d checked reports over directed, hold-off",
                 words_taken, reports_checked);
        $display("and random phases; saturated flag reported: %0d", saw_saturation);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
